// ----- hw/rtl/lsrt_pkg.sv -----
// Package: shared types, codes and helpers for the lap, speed and RPM telemetry block.
`default_nettype none

package lsrt_pkg;

    typedef enum logic [2:0] {
        REQ_TICK      = 3'd0,
        REQ_LAP       = 3'd1,
        REQ_WHEEL     = 3'd2,
        REQ_WHEEL_TO  = 3'd3,
        REQ_INJECT    = 3'd4,
        REQ_INJECT_TO = 3'd5
    } t_req;

    localparam logic [1:0] CFG_SPEED_CONST = 2'd0;
    localparam logic [1:0] CFG_RPM_CONST   = 2'd1;
    localparam logic [1:0] CFG_MIN_PERIOD  = 2'd2;

    localparam logic [19:0] SPEED_CONST_RST = 20'd455580;
    localparam logic [23:0] RPM_CONST_RST   = 24'd7500000;
    localparam logic [15:0] MIN_PERIOD_RST  = 16'd800;
    localparam logic [4:0]  LOCKOUT_TICKS   = 5'd30;
    localparam logic [3:0]  TENTHS_PER_SEC  = 4'd10;
    localparam logic [10:0] WHEEL_MM_TEN    = 11'd1548;
    localparam logic [15:0] WHEEL_DIV       = 16'd20;
    localparam logic [15:0] KMH_DEN         = 16'd1000;
    localparam logic [15:0] DIV_THREE       = 16'd3;
    localparam logic [15:0] DIV_TEN         = 16'd10;
    localparam logic [15:0] SMOOTH_MOVING   = 16'd15;
    localparam logic [15:0] SMOOTH_IDLE     = 16'd10;
    localparam logic [12:0] SMOOTH_MIN_WHL  = 13'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_RPM,
        ST_AVG,
        ST_SNAP,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_SPEED,
        OP_MEAN3,
        OP_RPM,
        OP_RPM10,
        OP_AVG20,
        OP_AVGSEC,
        OP_AVG1000,
        OP_SNAP3,
        OP_SNAP10
    } t_op;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] capture;
        logic        reset_held;
    } t_in_item;

    typedef struct packed {
        logic [15:0] run_seconds;
        logic [15:0] lap_time_1;
        logic [15:0] lap_time_2;
        logic [15:0] lap_time_3;
        logic [7:0]  lap_number;
        logic [7:0]  lap_number_prev;
        logic [7:0]  lap_number_older;
        logic [12:0] speed_whole;
        logic [3:0]  speed_tenths;
        logic [15:0] engine_rpm;
        logic [15:0] average_speed;
    } t_out_item;

    function automatic logic [15:0] sat16(input logic [47:0] v);
        logic [15:0] r;
        r = (v[47:16] != 32'd0) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lap_speed_rpm_telemetry.sv -----
// Top level: lap, speed, engine RPM and average speed telemetry with a bit-serial divider.
//
// Usage: each input item is one event (tick, lap press, wheel pulse, wheel
// timeout, injection pulse, injection timeout) and yields exactly one
// snapshot item on the output channel. Both channels use valid/stall; an
// item moves when valid is high and stall is low. The configuration
// channel (valid/ready, always ready) writes the speed constant, the RPM
// constant and the minimum wheel period; write it only while idle.
// One item is worked at a time. A shared restoring divider retires one
// quotient bit per cycle, and an item runs a chain of up to nine divisions
// (speed, smoothing mean, RPM, RPM tens, three average-speed steps and the
// snapshot mean and tens split).
// The snapshot waits in an output register, so input is taken again as
// soon as the snapshot is loaded there; a stalled receiver holds it and a
// second snapshot waits in the final state until the register frees.
// Reset (synchronous, active low) restores the register defaults, clears
// all counters and history and sets the reset-button lockout to 3 s.
`default_nettype none

module lap_speed_rpm_telemetry (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  lsrt_pkg::t_in_item      i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output lsrt_pkg::t_out_item     o_out_item,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [1:0]              i_cfg_index,
    input  wire  [23:0]             i_cfg_data
);

    lsrt_pkg::t_state r_state, n_state;
    lsrt_pkg::t_op    r_op;
    lsrt_pkg::t_in_item r_item;

    logic [19:0] r_speed_const;
    logic [23:0] r_rpm_const;
    logic [15:0] r_min_period;

    logic [15:0] r_seconds, r_lap_mark;
    logic [15:0] r_lap_times [3];
    logic [7:0]  r_lap_counts [3];
    logic [3:0]  r_tenth;
    logic [4:0]  r_lockout;
    logic        r_running, r_wheel_on, r_inject_on, r_rpm_valid;
    logic [15:0] r_wheel_period, r_inject_period, r_rpm, r_avg;
    logic [15:0] r_hist [3];
    logic [31:0] r_distance;
    logic [12:0] r_last_whole;
    logic [12:0] r_snap_whole;
    logic [3:0]  r_snap_tenths;

    // divider
    logic [47:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_div;
    logic [5:0]  r_cnt;

    logic        r_out_valid;
    lsrt_pkg::t_out_item r_out_item;

    logic [16:0] w_trial;
    logic        w_ge;
    logic        w_div_done;
    logic        w_accept;
    logic        w_out_free;
    logic [15:0] w_wp_next;
    logic        w_speed_go;
    logic [15:0] w_speed_v;
    logic [15:0] w_diff;
    logic        w_smooth;
    logic        w_rpm_go;
    logic        w_avg_go;
    logic [17:0] w_mean_sum;
    logic [17:0] w_snap_sum;
    logic [42:0] w_dist_prod;
    logic [44:0] w_avg_mul;
    logic [15:0] w_rpm_sat;
    logic [15:0] w_rpm_tens;

    assign w_trial    = {r_rem, r_quo[47]};
    assign w_ge       = (w_trial >= {1'b0, r_div});
    assign w_div_done = (r_state == lsrt_pkg::ST_DIV) && (r_cnt == 6'd0);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_wp_next  = r_wheel_on ? r_item.capture : r_wheel_period;
    assign w_speed_go = (r_item.req_type == lsrt_pkg::REQ_WHEEL) && (w_wp_next > r_min_period);

    assign w_speed_v  = lsrt_pkg::sat16({28'd0, r_quo[19:0]});
    assign w_diff     = (w_speed_v >= r_hist[1]) ? w_speed_v - r_hist[1] : r_hist[1] - w_speed_v;
    assign w_smooth   = ((w_diff > lsrt_pkg::SMOOTH_MOVING) &&
                         (r_last_whole > lsrt_pkg::SMOOTH_MIN_WHL) && (r_rpm != 16'd0)) ||
                        ((r_rpm == 16'd0) && (w_diff > lsrt_pkg::SMOOTH_IDLE));
    assign w_mean_sum = {2'd0, r_hist[0]} + {2'd0, r_hist[1]} + {2'd0, w_speed_v};
    assign w_snap_sum = {2'd0, r_hist[0]} + {2'd0, r_hist[1]} + {2'd0, r_hist[2]};

    assign w_rpm_go   = r_rpm_valid && (r_inject_period != 16'd0);
    assign w_avg_go   = (r_distance != 32'd0) && (r_seconds != 16'd0);
    assign w_dist_prod = {11'd0, r_distance} * {32'd0, lsrt_pkg::WHEEL_MM_TEN};
    // times 36 as two shifted adds
    assign w_avg_mul  = {1'b0, r_quo[38:0], 5'd0} + {4'd0, r_quo[38:0], 2'd0};
    assign w_rpm_sat  = lsrt_pkg::sat16({24'd0, r_quo[23:0]});
    assign w_rpm_tens = {r_quo[12:0], 3'd0} + {2'd0, r_quo[12:0], 1'b0};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsrt_pkg::ST_IDLE:  if (w_accept) n_state = lsrt_pkg::ST_APPLY;
            lsrt_pkg::ST_APPLY: n_state = w_speed_go ? lsrt_pkg::ST_DIV : lsrt_pkg::ST_RPM;
            lsrt_pkg::ST_RPM:   n_state = w_rpm_go ? lsrt_pkg::ST_DIV : lsrt_pkg::ST_AVG;
            lsrt_pkg::ST_AVG:   n_state = w_avg_go ? lsrt_pkg::ST_DIV : lsrt_pkg::ST_SNAP;
            lsrt_pkg::ST_SNAP:  n_state = lsrt_pkg::ST_DIV;
            lsrt_pkg::ST_DIV: begin
                if (w_div_done) begin
                    case (r_op)
                        lsrt_pkg::OP_SPEED:   n_state = w_smooth ? lsrt_pkg::ST_DIV
                                                                 : lsrt_pkg::ST_RPM;
                        lsrt_pkg::OP_MEAN3:   n_state = lsrt_pkg::ST_RPM;
                        lsrt_pkg::OP_RPM10:   n_state = lsrt_pkg::ST_AVG;
                        lsrt_pkg::OP_AVG1000: n_state = lsrt_pkg::ST_SNAP;
                        lsrt_pkg::OP_SNAP10:  n_state = lsrt_pkg::ST_OUT;
                        default:              n_state = lsrt_pkg::ST_DIV;
                    endcase
                end
            end
            lsrt_pkg::ST_OUT:   if (w_out_free) n_state = lsrt_pkg::ST_IDLE;
            default:            n_state = lsrt_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != lsrt_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;
        o_out_valid = r_out_valid;
        o_out_item  = r_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsrt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == lsrt_pkg::ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lsrt_pkg::ST_OUT && w_out_free) begin
            r_out_item.run_seconds      <= r_seconds;
            r_out_item.lap_time_1       <= r_lap_times[0];
            r_out_item.lap_time_2       <= r_lap_times[1];
            r_out_item.lap_time_3       <= r_lap_times[2];
            r_out_item.lap_number       <= r_lap_counts[0];
            r_out_item.lap_number_prev  <= r_lap_counts[1];
            r_out_item.lap_number_older <= r_lap_counts[2];
            r_out_item.speed_whole      <= r_snap_whole;
            r_out_item.speed_tenths     <= r_snap_tenths;
            r_out_item.engine_rpm       <= r_rpm;
            r_out_item.average_speed    <= r_avg;
        end
        if (w_accept) begin
            r_item <= i_in_item;
        end
    end

    // divider datapath and launches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
            r_op  <= lsrt_pkg::OP_SPEED;
        end else begin
            if (r_state == lsrt_pkg::ST_DIV && r_cnt != 6'd0) begin
                r_rem <= w_ge ? 16'(w_trial - {1'b0, r_div}) : w_trial[15:0];
                r_quo <= {r_quo[46:0], w_ge};
                r_cnt <= r_cnt - 6'd1;
            end
            case (r_state)
                lsrt_pkg::ST_APPLY: begin
                    if (w_speed_go) begin
                        r_quo <= {r_speed_const, 28'd0};
                        r_rem <= 16'd0;
                        r_div <= w_wp_next;
                        r_cnt <= 6'd20;
                        r_op  <= lsrt_pkg::OP_SPEED;
                    end
                end
                lsrt_pkg::ST_RPM: begin
                    if (w_rpm_go) begin
                        r_quo <= {r_rpm_const, 24'd0};
                        r_rem <= 16'd0;
                        r_div <= r_inject_period;
                        r_cnt <= 6'd24;
                        r_op  <= lsrt_pkg::OP_RPM;
                    end
                end
                lsrt_pkg::ST_AVG: begin
                    if (w_avg_go) begin
                        r_quo <= {w_dist_prod, 5'd0};
                        r_rem <= 16'd0;
                        r_div <= lsrt_pkg::WHEEL_DIV;
                        r_cnt <= 6'd43;
                        r_op  <= lsrt_pkg::OP_AVG20;
                    end
                end
                lsrt_pkg::ST_SNAP: begin
                    r_quo <= {w_snap_sum, 30'd0};
                    r_rem <= 16'd0;
                    r_div <= lsrt_pkg::DIV_THREE;
                    r_cnt <= 6'd18;
                    r_op  <= lsrt_pkg::OP_SNAP3;
                end
                lsrt_pkg::ST_DIV: begin
                    if (w_div_done) begin
                        r_rem <= 16'd0;
                        case (r_op)
                            lsrt_pkg::OP_SPEED: begin
                                r_quo <= {w_mean_sum, 30'd0};
                                r_div <= lsrt_pkg::DIV_THREE;
                                r_cnt <= w_smooth ? 6'd18 : 6'd0;
                                r_op  <= lsrt_pkg::OP_MEAN3;
                            end
                            lsrt_pkg::OP_RPM: begin
                                r_quo <= {w_rpm_sat, 32'd0};
                                r_div <= lsrt_pkg::DIV_TEN;
                                r_cnt <= 6'd16;
                                r_op  <= lsrt_pkg::OP_RPM10;
                            end
                            lsrt_pkg::OP_AVG20: begin
                                r_quo <= {r_quo[38:0], 9'd0};
                                r_div <= r_seconds;
                                r_cnt <= 6'd39;
                                r_op  <= lsrt_pkg::OP_AVGSEC;
                            end
                            lsrt_pkg::OP_AVGSEC: begin
                                r_quo <= {w_avg_mul, 3'd0};
                                r_div <= lsrt_pkg::KMH_DEN;
                                r_cnt <= 6'd45;
                                r_op  <= lsrt_pkg::OP_AVG1000;
                            end
                            lsrt_pkg::OP_SNAP3: begin
                                r_quo <= {r_quo[15:0], 32'd0};
                                r_div <= lsrt_pkg::DIV_TEN;
                                r_cnt <= 6'd16;
                                r_op  <= lsrt_pkg::OP_SNAP10;
                            end
                            default: begin
                                r_cnt <= 6'd0;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // configuration and telemetry state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_const   <= lsrt_pkg::SPEED_CONST_RST;
            r_rpm_const     <= lsrt_pkg::RPM_CONST_RST;
            r_min_period    <= lsrt_pkg::MIN_PERIOD_RST;
            r_seconds       <= 16'd0;
            r_lap_mark      <= 16'd0;
            r_lap_times     <= '{default: 16'd0};
            r_lap_counts    <= '{default: 8'd0};
            r_tenth         <= 4'd0;
            r_lockout       <= lsrt_pkg::LOCKOUT_TICKS;
            r_running       <= 1'b0;
            r_wheel_on      <= 1'b0;
            r_inject_on     <= 1'b0;
            r_rpm_valid     <= 1'b0;
            r_wheel_period  <= 16'd0;
            r_inject_period <= 16'd0;
            r_rpm           <= 16'd0;
            r_avg           <= 16'd0;
            r_hist          <= '{default: 16'd0};
            r_distance      <= 32'd0;
            r_last_whole    <= 13'd0;
            r_snap_whole    <= 13'd0;
            r_snap_tenths   <= 4'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lsrt_pkg::CFG_SPEED_CONST: r_speed_const <= i_cfg_data[19:0];
                    lsrt_pkg::CFG_RPM_CONST:   r_rpm_const   <= i_cfg_data;
                    lsrt_pkg::CFG_MIN_PERIOD:  r_min_period  <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                lsrt_pkg::ST_APPLY: begin
                    case (r_item.req_type)
                        lsrt_pkg::REQ_TICK: begin
                            r_tenth <= (r_tenth + 4'd1 >= lsrt_pkg::TENTHS_PER_SEC)
                                       ? 4'd0 : r_tenth + 4'd1;
                            if (r_lockout != 5'd0) begin
                                r_lockout <= r_lockout - 5'd1;
                            end
                            if (r_lockout == 5'd0 && r_item.reset_held) begin
                                // run reset; running drops so seconds holds at zero
                                r_running       <= 1'b0;
                                r_seconds       <= 16'd0;
                                r_lap_mark      <= 16'd0;
                                r_lap_times     <= '{default: 16'd0};
                                r_lap_counts    <= '{default: 8'd0};
                                r_wheel_period  <= 16'd0;
                                r_hist          <= '{default: 16'd0};
                                r_inject_period <= 16'd0;
                                r_rpm           <= 16'd0;
                                r_distance      <= 32'd0;
                                r_avg           <= 16'd0;
                            end else if (r_tenth + 4'd1 >= lsrt_pkg::TENTHS_PER_SEC &&
                                         r_running) begin
                                r_seconds <= r_seconds + 16'd1;
                            end
                        end
                        lsrt_pkg::REQ_LAP: begin
                            r_lockout <= lsrt_pkg::LOCKOUT_TICKS;
                            if (r_seconds != r_lap_mark) begin
                                r_lap_times[2]  <= r_lap_times[1];
                                r_lap_times[1]  <= r_lap_times[0];
                                r_lap_times[0]  <= r_seconds - r_lap_mark;
                                r_lap_mark      <= r_seconds;
                                r_lap_counts[2] <= r_lap_counts[1];
                                r_lap_counts[1] <= r_lap_counts[0];
                                r_lap_counts[0] <= r_lap_counts[0] + 8'd1;
                            end
                        end
                        lsrt_pkg::REQ_WHEEL: begin
                            r_running      <= 1'b1;
                            r_wheel_on     <= 1'b1;
                            r_wheel_period <= w_wp_next;
                            r_distance     <= r_distance + 32'd1;
                            if (w_speed_go) begin
                                r_hist[0] <= r_hist[1];
                                r_hist[1] <= r_hist[2];
                            end else begin
                                r_hist <= '{default: 16'd0};
                            end
                        end
                        lsrt_pkg::REQ_WHEEL_TO: begin
                            r_wheel_on      <= 1'b0;
                            r_wheel_period  <= 16'd0;
                            r_hist          <= '{default: 16'd0};
                            r_inject_period <= 16'd0;
                        end
                        lsrt_pkg::REQ_INJECT: begin
                            if (r_inject_on) begin
                                r_inject_period <= r_item.capture;
                            end
                            r_inject_on <= 1'b1;
                            r_rpm_valid <= 1'b1;
                        end
                        lsrt_pkg::REQ_INJECT_TO: begin
                            r_inject_on     <= 1'b0;
                            r_rpm_valid     <= 1'b0;
                            r_inject_period <= 16'd0;
                            r_rpm           <= 16'd0;
                        end
                        default: begin
                        end
                    endcase
                end
                lsrt_pkg::ST_RPM: begin
                    if (!w_rpm_go) begin
                        r_rpm <= 16'd0;
                    end
                end
                lsrt_pkg::ST_AVG: begin
                    if (!w_avg_go) begin
                        r_avg <= 16'd0;
                    end
                end
                lsrt_pkg::ST_DIV: begin
                    if (w_div_done) begin
                        case (r_op)
                            lsrt_pkg::OP_SPEED: begin
                                // keep raw speed; the mean replaces it when smoothing
                                r_hist[2] <= w_speed_v;
                            end
                            lsrt_pkg::OP_MEAN3:   r_hist[2] <= r_quo[15:0];
                            lsrt_pkg::OP_RPM10:   r_rpm     <= w_rpm_tens;
                            lsrt_pkg::OP_AVG1000: r_avg     <= lsrt_pkg::sat16({3'd0, r_quo[44:0]});
                            lsrt_pkg::OP_SNAP10: begin
                                r_snap_whole  <= r_quo[12:0];
                                r_snap_tenths <= r_rem[3:0];
                                r_last_whole  <= r_quo[12:0];
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- bench/lap_speed_rpm_telemetry_tb.sv -----
// Testbench for the lap, speed and RPM telemetry block: directed and random events.
`default_nettype none

module lap_speed_rpm_telemetry_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    lsrt_pkg::t_in_item  i_in_item;
    logic                o_out_valid;
    logic                i_out_stall;
    lsrt_pkg::t_out_item o_out_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [23:0]         i_cfg_data;

    lap_speed_rpm_telemetry dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predicted block state
    logic [19:0] speed_k;
    logic [23:0] rpm_k;
    logic [15:0] min_period;
    logic [15:0] secs, mark;
    logic [15:0] laps [3];
    logic [7:0]  lapn [3];
    logic [3:0]  tenths;
    logic [4:0]  lockout;
    logic        moving, wheel_on, inj_on, rpm_ok;
    logic [15:0] wperiod, iperiod, rpm, avg;
    logic [15:0] hist [3];
    logic [31:0] pulses;
    logic [12:0] prev_whole;

    lsrt_pkg::t_out_item snapshot_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          quiet = 0;
    int          stall_pct = 6;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [15:0] sat(input logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic clear_run();
        moving = 0; secs = '0; mark = '0; wperiod = '0; iperiod = '0;
        rpm = '0; pulses = '0; avg = '0;
        for (int k = 0; k < 3; k++) begin
            laps[k] = '0; lapn[k] = '0; hist[k] = '0;
        end
    endtask

    task automatic predict_snapshot(input lsrt_pkg::t_in_item it);
        logic [31:0] v, d, s;
        logic [63:0] q;
        lsrt_pkg::t_out_item o;
        case (it.req_type)
            lsrt_pkg::REQ_TICK: begin
                tenths = tenths + 4'd1;
                if (lockout != 0) lockout = lockout - 5'd1;
                else if (it.reset_held) clear_run();
                if (tenths >= lsrt_pkg::TENTHS_PER_SEC) begin
                    tenths = 4'd0;
                    if (moving) secs = secs + 16'd1;
                end
            end
            lsrt_pkg::REQ_LAP: begin
                lockout = lsrt_pkg::LOCKOUT_TICKS;
                if (secs != mark) begin
                    laps[2] = laps[1]; laps[1] = laps[0]; laps[0] = secs - mark;
                    mark = secs;
                    lapn[2] = lapn[1]; lapn[0] = lapn[0] + 8'd1; lapn[1] = lapn[0] - 8'd1;
                end
            end
            lsrt_pkg::REQ_WHEEL: begin
                moving = 1;
                if (!wheel_on) wheel_on = 1;
                else wperiod = it.capture;
                pulses = pulses + 32'd1;
                if (wperiod <= min_period) begin
                    for (int k = 0; k < 3; k++) hist[k] = '0;
                end else begin
                    hist[0] = hist[1]; hist[1] = hist[2];
                    v = {16'd0, sat(64'(speed_k) / 64'(wperiod))};
                    hist[2] = v[15:0];
                    d = (v >= 32'(hist[1])) ? v - 32'(hist[1]) : 32'(hist[1]) - v;
                    if ((d > 15 && prev_whole > 10 && rpm != 0) || (rpm == 0 && d > 10)) begin
                        s = 32'(hist[0]) + 32'(hist[1]) + 32'(hist[2]);
                        hist[2] = 16'(s / 32'd3);
                    end
                end
            end
            lsrt_pkg::REQ_WHEEL_TO: begin
                wheel_on = 0; wperiod = '0; iperiod = '0;
                for (int k = 0; k < 3; k++) hist[k] = '0;
            end
            lsrt_pkg::REQ_INJECT: begin
                if (!inj_on) inj_on = 1;
                else iperiod = it.capture;
                rpm_ok = 1;
            end
            lsrt_pkg::REQ_INJECT_TO: begin
                inj_on = 0; rpm_ok = 0; iperiod = '0; rpm = '0;
            end
            default: ;
        endcase
        if (!rpm_ok || iperiod == 0) rpm = '0;
        else begin
            v = {16'd0, sat(64'(rpm_k) / 64'(iperiod))};
            rpm = 16'((v / 32'd10) * 32'd10);
        end
        if (pulses == 0 || secs == 0) avg = '0;
        else begin
            q = ((64'(pulses) * 64'd1548 / 64'd20) / 64'(secs)) * 64'd36 / 64'd1000;
            avg = sat(q);
        end
        s = (32'(hist[0]) + 32'(hist[1]) + 32'(hist[2])) / 32'd3;
        prev_whole = 13'(s / 32'd10);
        o.run_seconds = secs;
        o.lap_time_1 = laps[0]; o.lap_time_2 = laps[1]; o.lap_time_3 = laps[2];
        o.lap_number = lapn[0]; o.lap_number_prev = lapn[1]; o.lap_number_older = lapn[2];
        o.speed_whole = 13'(s / 32'd10);
        o.speed_tenths = 4'(s % 32'd10);
        o.engine_rpm = rpm;
        o.average_speed = avg;
        snapshot_q.push_back(o);
    endtask

    // check every accepted snapshot
    always @(posedge i_clk) begin
        lsrt_pkg::t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (snapshot_q.size() == 0) begin
                $error("unexpected snapshot");
                errors++;
            end else begin
                e = snapshot_q.pop_front();
                if (e.run_seconds !== o_out_item.run_seconds) begin
                    $error("run_seconds exp %0d got %0d", e.run_seconds,
                           o_out_item.run_seconds); errors++; end
                if (e.lap_time_1 !== o_out_item.lap_time_1) begin
                    $error("lap_time_1 exp %0d got %0d", e.lap_time_1,
                           o_out_item.lap_time_1); errors++; end
                if (e.lap_time_2 !== o_out_item.lap_time_2) begin
                    $error("lap_time_2 exp %0d got %0d", e.lap_time_2,
                           o_out_item.lap_time_2); errors++; end
                if (e.lap_time_3 !== o_out_item.lap_time_3) begin
                    $error("lap_time_3 exp %0d got %0d", e.lap_time_3,
                           o_out_item.lap_time_3); errors++; end
                if (e.lap_number !== o_out_item.lap_number) begin
                    $error("lap_number exp %0d got %0d", e.lap_number,
                           o_out_item.lap_number); errors++; end
                if (e.lap_number_prev !== o_out_item.lap_number_prev) begin
                    $error("lap_number_prev exp %0d got %0d", e.lap_number_prev,
                           o_out_item.lap_number_prev); errors++; end
                if (e.lap_number_older !== o_out_item.lap_number_older) begin
                    $error("lap_number_older exp %0d got %0d", e.lap_number_older,
                           o_out_item.lap_number_older); errors++; end
                if (e.speed_whole !== o_out_item.speed_whole) begin
                    $error("speed_whole exp %0d got %0d", e.speed_whole,
                           o_out_item.speed_whole); errors++; end
                if (e.speed_tenths !== o_out_item.speed_tenths) begin
                    $error("speed_tenths exp %0d got %0d", e.speed_tenths,
                           o_out_item.speed_tenths); errors++; end
                if (e.engine_rpm !== o_out_item.engine_rpm) begin
                    $error("engine_rpm exp %0d got %0d", e.engine_rpm,
                           o_out_item.engine_rpm); errors++; end
                if (e.average_speed !== o_out_item.average_speed) begin
                    $error("average_speed exp %0d got %0d", e.average_speed,
                           o_out_item.average_speed); errors++; end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk)
        i_out_stall <= !quiet && ($urandom_range(99) < stall_pct);

    task automatic send_event(input lsrt_pkg::t_req req, input logic [15:0] cap,
                              input logic held);
        lsrt_pkg::t_in_item it;
        // step past the negedge that dropped the previous valid
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < stall_pct) @(negedge i_clk);
        it.req_type = req; it.capture = cap; it.reset_held = held;
        i_in_item <= it;
        i_in_valid <= 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_snapshot(it);
        @(negedge i_clk);
        i_in_valid <= 0;
    endtask

    task automatic send_raw(input logic [2:0] code, input logic [15:0] cap, input logic held);
        send_event(lsrt_pkg::t_req'(code), cap, held);
    endtask

    task automatic drain();
        while (snapshot_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        drain();
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            lsrt_pkg::CFG_SPEED_CONST: speed_k = val[19:0];
            lsrt_pkg::CFG_RPM_CONST:   rpm_k = val;
            lsrt_pkg::CFG_MIN_PERIOD:  min_period = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic test_directed();
        send_event(lsrt_pkg::REQ_TICK, 16'hFFFF, 1);
        send_event(lsrt_pkg::REQ_LAP, 0, 0);
        send_event(lsrt_pkg::REQ_WHEEL, 16'hFFFF, 1);
        send_event(lsrt_pkg::REQ_WHEEL, 100, 0);
        send_event(lsrt_pkg::REQ_WHEEL, 16'hFFFF, 0);
        send_event(lsrt_pkg::REQ_WHEEL, 1000, 0);
        send_event(lsrt_pkg::REQ_WHEEL, 2000, 0);
        send_event(lsrt_pkg::REQ_INJECT, 0, 0);
        send_event(lsrt_pkg::REQ_INJECT, 1, 0);
        send_event(lsrt_pkg::REQ_INJECT, 16'hFFFF, 0);
        send_event(lsrt_pkg::REQ_WHEEL, 900, 0);
        for (int k = 0; k < 12; k++) send_event(lsrt_pkg::REQ_TICK, 0, 0);
        send_event(lsrt_pkg::REQ_LAP, 0, 0);
        send_raw(3'd6, 16'h5555, 1);
        send_raw(3'd7, 16'hAAAA, 0);
        send_event(lsrt_pkg::REQ_WHEEL_TO, 0, 0);
        send_event(lsrt_pkg::REQ_INJECT_TO, 0, 0);
    endtask

    // random ticks, laps, wheel and injection pulses, timeouts and unused codes, reset sometimes held
    task automatic test_random(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (k % 500 == 250) quiet = 1;
            if (k % 500 == 400) quiet = 0;
            if (r < 45)
                send_event(lsrt_pkg::REQ_TICK, 16'($urandom), ($urandom_range(30) == 0));
            else if (r < 50) send_event(lsrt_pkg::REQ_LAP, 16'($urandom), 1'($urandom));
            else if (r < 75)
                send_event(lsrt_pkg::REQ_WHEEL, ($urandom_range(3) == 0) ? 16'($urandom)
                           : 16'($urandom_range(700, 3000)), 1'($urandom));
            else if (r < 77)
                send_event(lsrt_pkg::REQ_WHEEL_TO, 16'($urandom), 1'($urandom));
            else if (r < 93)
                send_event(lsrt_pkg::REQ_INJECT, ($urandom_range(3) == 0) ? 16'($urandom)
                           : 16'($urandom_range(100, 4000)), 1'($urandom));
            else if (r < 95)
                send_event(lsrt_pkg::REQ_INJECT_TO, 16'($urandom), 1'($urandom));
            else send_raw(3'($urandom_range(7)), 16'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_settings();
        write_reg(lsrt_pkg::CFG_SPEED_CONST, 24'hFFFFF);
        write_reg(lsrt_pkg::CFG_RPM_CONST, 24'hFFFFFF);
        write_reg(lsrt_pkg::CFG_MIN_PERIOD, 0);
        test_random(300);
        write_reg(lsrt_pkg::CFG_SPEED_CONST, 0);
        write_reg(lsrt_pkg::CFG_RPM_CONST, 0);
        write_reg(lsrt_pkg::CFG_MIN_PERIOD, 16'hFFFF);
        test_random(200);
        write_reg(lsrt_pkg::CFG_SPEED_CONST, 24'd20000);
        write_reg(lsrt_pkg::CFG_RPM_CONST, 24'd900000);
        write_reg(lsrt_pkg::CFG_MIN_PERIOD, 16'd50);
        test_random(300);
        write_reg(lsrt_pkg::CFG_SPEED_CONST, 24'(lsrt_pkg::SPEED_CONST_RST));
        write_reg(lsrt_pkg::CFG_RPM_CONST, lsrt_pkg::RPM_CONST_RST);
        write_reg(lsrt_pkg::CFG_MIN_PERIOD, 24'(lsrt_pkg::MIN_PERIOD_RST));
    endtask

    initial begin
        i_rst_n = 0; i_in_valid = 0; i_in_item = '0; i_out_stall = 0;
        i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        speed_k = lsrt_pkg::SPEED_CONST_RST; rpm_k = lsrt_pkg::RPM_CONST_RST;
        min_period = lsrt_pkg::MIN_PERIOD_RST;
        clear_run();
        tenths = '0; lockout = lsrt_pkg::LOCKOUT_TICKS; wheel_on = 0; inj_on = 0; rpm_ok = 0;
        prev_whole = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;
        test_directed();
        test_random(1100);
        test_settings();
        drain();
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire

// ----- lap_speed_rpm_telemetry.f -----
hw/rtl/lsrt_pkg.sv
hw/rtl/lap_speed_rpm_telemetry.sv
bench/lap_speed_rpm_telemetry_tb.sv
